/* hw/rtl/tcs_pkg.sv */
// Package: codes, phase type and sizes for the thruster calibration sequencer.
`default_nettype none

package tcs_pkg;

    localparam int MAX_THRUSTERS = 40;

    localparam int NUM_W   = 6;
    localparam int TEST_W  = 7;
    localparam int TIME_W  = 32;
    localparam int TC_W    = 3;
    localparam int DC_W    = 2;
    localparam int PR_W    = 2;
    localparam int IN_DW   = 32;
    localparam int IN_UW   = 1;
    localparam int OUT_DW  = 16;

    localparam logic IN_OP_TICK    = 1'b0;
    localparam logic IN_OP_RESTART = 1'b1;

    localparam logic [TC_W-1:0] TC_NONE    = 3'd0;
    localparam logic [TC_W-1:0] TC_STOP    = 3'd1;
    localparam logic [TC_W-1:0] TC_FWD     = 3'd2;
    localparam logic [TC_W-1:0] TC_BWD     = 3'd3;
    localparam logic [TC_W-1:0] TC_RELEASE = 3'd4;

    localparam logic [DC_W-1:0] DC_NONE  = 2'd0;
    localparam logic [DC_W-1:0] DC_START = 2'd1;
    localparam logic [DC_W-1:0] DC_STOP  = 2'd2;
    localparam logic [DC_W-1:0] DC_DUMP  = 2'd3;

    localparam logic [PR_W-1:0] PR_NONE     = 2'd0;
    localparam logic [PR_W-1:0] PR_NOSE     = 2'd1;
    localparam logic [PR_W-1:0] PR_SIDE     = 2'd2;
    localparam logic [PR_W-1:0] PR_RELEASE  = 2'd3;

    localparam logic [TIME_W-1:0] SETTLE_S   = 32'd1;
    localparam logic [TIME_W-1:0] RUN_S      = 32'd5;
    localparam logic [TIME_W-1:0] REST_S     = 32'd14;
    localparam logic [TIME_W-1:0] ORIENT_S   = 32'd15;
    localparam logic [TIME_W-1:0] LOG_S      = 32'd6;

    typedef enum logic [2:0] {
        PH_1 = 3'd1,
        PH_2 = 3'd2,
        PH_3 = 3'd3,
        PH_4 = 3'd4,
        PH_5 = 3'd5
    } phase_t;

endpackage

`default_nettype wire

/* hw/rtl/thruster_calibration_sequencer_top.sv */
// Top level: timed thruster calibration sequencer with stream ports.
// A word accepted passes through the input register, then the result register,
// which holds its result word. Throughput: one word per cycle, set by the
// combinational phase decision between the two registers; either side may stall.
// Reset (aresetn low, synchronous): idle and complete, test 0, phase 1, N = 1,
// num_thrusters register 1, both stages empty.
`default_nettype none

module thruster_calibration_sequencer_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tcs_pkg::NUM_W-1:0]     cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [tcs_pkg::IN_DW-1:0]     s_tdata,  // [31:0] present_time
    input  wire logic [tcs_pkg::IN_UW-1:0]     s_tuser,  // [0] op
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [tcs_pkg::OUT_DW-1:0]         m_tdata   // [6:0] test_index,
                                                         // [9:7] thruster_cmd,
                                                         // [11:10] data_cmd,
                                                         // [13:12] prompt,
                                                         // [14] complete, [15] 0
);
    import tcs_pkg::*;

    logic [NUM_W-1:0]  num_reg;
    logic              in_vld_reg;
    logic              op_reg;
    logic [TIME_W-1:0] time_reg;
    logic              out_vld_reg;
    logic [OUT_DW-1:0] out_reg;

    logic              armed_reg, armed_next;
    logic [TEST_W-1:0] test_reg, test_next;
    phase_t            phase_reg, phase_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [NUM_W-1:0]  n_reg, n_next;

    logic              advance;
    logic [TEST_W-1:0] total;
    logic              done;
    logic              orient;
    logic              restart_ok;
    logic [TIME_W-1:0] diff;

    logic [TEST_W-1:0] res_idx;
    logic [TC_W-1:0]   res_tc;
    logic [DC_W-1:0]   res_dc;
    logic [PR_W-1:0]   res_pr;
    logic              res_done;

    assign cfg_ready = 1'b1;
    assign advance   = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || advance;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_reg;

    assign total      = {n_reg, 1'b0} + TEST_W'(2);
    assign done       = test_reg >= total;
    assign orient     = test_reg >= (total - TEST_W'(2));
    assign restart_ok = (num_reg != '0) && (num_reg <= NUM_W'(MAX_THRUSTERS));
    assign diff       = time_reg - start_reg;

    // next state
    always_comb begin
        armed_next = armed_reg;
        test_next  = test_reg;
        phase_next = phase_reg;
        start_next = start_reg;
        n_next     = n_reg;
        if (op_reg == IN_OP_RESTART) begin
            if (restart_ok) begin
                armed_next = 1'b1;
                test_next  = '0;
                phase_next = PH_1;
                n_next     = num_reg;
            end
        end else if (armed_reg && !done) begin
            if (!orient) begin
                case (phase_reg)
                    PH_1: begin
                        start_next = time_reg;
                        phase_next = PH_2;
                    end
                    PH_2: begin
                        if (diff > SETTLE_S) begin
                            start_next = time_reg;
                            phase_next = PH_3;
                        end
                    end
                    PH_3: begin
                        if (diff > RUN_S) begin
                            phase_next = PH_4;
                        end
                    end
                    PH_4: begin
                        start_next = time_reg;
                        phase_next = PH_5;
                    end
                    PH_5: begin
                        if (diff >= REST_S) begin
                            phase_next = PH_1;
                            test_next  = test_reg + TEST_W'(1);
                        end
                    end
                    default: ;
                endcase
            end else begin
                case (phase_reg)
                    PH_1: begin
                        start_next = time_reg;
                        phase_next = PH_2;
                    end
                    PH_2: begin
                        if (diff >= ORIENT_S) begin
                            phase_next = PH_3;
                        end
                    end
                    PH_3: begin
                        start_next = time_reg;
                        phase_next = PH_4;
                    end
                    PH_4: begin
                        if (diff >= LOG_S) begin
                            phase_next = PH_5;
                        end
                    end
                    PH_5: begin
                        test_next  = test_reg + TEST_W'(1);
                        phase_next = PH_1;
                        start_next = time_reg;
                    end
                    default: ;
                endcase
            end
        end
    end

    // result fields
    always_comb begin
        res_tc = TC_NONE;
        res_dc = DC_NONE;
        res_pr = PR_NONE;
        if (!armed_reg) begin
            res_idx  = '0;
            res_done = 1'b1;
        end else if (done) begin
            res_idx  = test_reg - TEST_W'(1);
            res_done = 1'b1;
        end else begin
            res_idx  = test_reg;
            res_done = 1'b0;
        end
        if (op_reg == IN_OP_RESTART) begin
            if (restart_ok) begin
                res_idx  = '0;
                res_done = 1'b0;
            end
        end else if (armed_reg && !done) begin
            if (!orient) begin
                case (phase_reg)
                    PH_1: res_dc = DC_START;
                    PH_2: begin
                        if (diff > SETTLE_S) begin
                            res_tc = test_reg[0] ? TC_BWD : TC_FWD;
                        end
                    end
                    PH_3: begin
                        if (diff > RUN_S) begin
                            res_tc = TC_STOP;
                            res_dc = DC_STOP;
                        end
                    end
                    PH_4: res_dc = DC_DUMP;
                    default: ;
                endcase
            end else begin
                case (phase_reg)
                    PH_1: res_pr = test_reg[0] ? PR_NOSE : PR_SIDE;
                    PH_2: begin
                        if (diff >= ORIENT_S) begin
                            res_dc = DC_START;
                        end
                    end
                    PH_3: begin
                        res_tc = TC_RELEASE;
                        res_pr = PR_RELEASE;
                    end
                    PH_4: begin
                        if (diff >= LOG_S) begin
                            res_dc = DC_STOP;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_reg     <= NUM_W'(1);
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            armed_reg   <= 1'b0;
            test_reg    <= '0;
            phase_reg   <= PH_1;
            start_reg   <= '0;
            n_reg       <= NUM_W'(1);
        end else begin
            if (cfg_valid && cfg_ready) begin
                num_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
                armed_reg   <= armed_next;
                test_reg    <= test_next;
                phase_reg   <= phase_next;
                start_reg   <= start_next;
                n_reg       <= n_next;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg   <= s_tuser[0];
            time_reg <= s_tdata;
        end
        if (advance) begin
            out_reg <= {1'b0, res_done, res_pr, res_dc, res_tc, res_idx};
        end
    end

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Testbench for the thruster calibration sequencer: directed table, then random timed sequences.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int WORDS_TOTAL = 1430;
    localparam int WORDS_CALM  = 1200;

    typedef struct packed {
        logic            pad;
        logic            done;
        logic [PR_W-1:0] pr;
        logic [DC_W-1:0] dc;
        logic [TC_W-1:0] tc;
        logic [TEST_W-1:0] idx;
    } cmd_set_t;

    typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic              op;
        logic [TIME_W-1:0] val;
        logic              lit;
        cmd_set_t          want;
    } row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [NUM_W-1:0]    cfg_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_DW-1:0]    s_tdata = '0;
    logic [IN_UW-1:0]    s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_DW-1:0]   m_tdata;

    // literal expectation travels beside the word it belongs to
    logic                lit_flag = 1'b0;
    cmd_set_t            lit_word = '0;

    cmd_set_t            cmd_sets_due[$];
    int                  words_fed = 0;
    int                  sets_seen = 0;
    int                  faults = 0;
    int                  cycles = 0;
    bit                  calm = 0;
    bit                  src_jitter = 1;
    bit                  sink_jitter = 1;
    int                  stall_left = 0;

    logic                seq_armed = 1'b0;
    logic [TEST_W-1:0]   seq_test = '0;
    phase_t              seq_phase = PH_1;
    logic [TIME_W-1:0]   seq_mark = '0;
    logic [NUM_W-1:0]    seq_n = 6'd1;
    logic [NUM_W-1:0]    n_reg = 6'd1;

    thruster_calibration_sequencer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [31:0] present_time
        .s_tuser   (s_tuser),   // [0] op
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // [6:0] index, [9:7] thruster, [11:10] data, [13:12] prompt,
                                // [14] complete, [15] 0
    );

    always #5 aclk = ~aclk;

    function automatic cmd_set_t cmd_set(input logic [TEST_W-1:0] idx, input logic [TC_W-1:0] tc,
                                         input logic [DC_W-1:0] dc, input logic [PR_W-1:0] pr,
                                         input logic done);
        cmd_set_t r;
        r = '0;
        r.idx = idx;
        r.tc = tc;
        r.dc = dc;
        r.pr = pr;
        r.done = done;
        return r;
    endfunction

    function automatic cmd_set_t sequencer_status();
        int total;
        total = 2 * int'(seq_n) + 2;
        if (!seq_armed)
            return cmd_set('0, TC_NONE, DC_NONE, PR_NONE, 1'b1);
        if (int'(seq_test) >= total)
            return cmd_set(seq_test - 7'd1, TC_NONE, DC_NONE, PR_NONE, 1'b1);
        return cmd_set(seq_test, TC_NONE, DC_NONE, PR_NONE, 1'b0);
    endfunction

    function automatic cmd_set_t next_cmd_set(input logic op, input logic [TIME_W-1:0] t);
        int total;
        logic [TIME_W-1:0] gap;
        logic [TEST_W-1:0] idx;
        logic [TC_W-1:0] tc;
        logic [DC_W-1:0] dc;
        logic [PR_W-1:0] pr;
        tc = TC_NONE;
        dc = DC_NONE;
        pr = PR_NONE;
        if (op == IN_OP_RESTART) begin
            if (n_reg >= 1 && int'(n_reg) <= MAX_THRUSTERS) begin
                seq_n = n_reg;
                seq_armed = 1'b1;
                seq_test = '0;
                seq_phase = PH_1;
            end
            return sequencer_status();
        end
        total = 2 * int'(seq_n) + 2;
        if (!seq_armed || int'(seq_test) >= total)
            return sequencer_status();
        idx = seq_test;
        gap = t - seq_mark;
        if (int'(seq_test) < total - 2) begin
            case (seq_phase)
                PH_1: begin
                    dc = DC_START;
                    seq_mark = t;
                    seq_phase = PH_2;
                end
                PH_2: if (gap > SETTLE_S) begin
                    tc = seq_test[0] ? TC_BWD : TC_FWD;
                    seq_mark = t;
                    seq_phase = PH_3;
                end
                PH_3: if (gap > RUN_S) begin
                    tc = TC_STOP;
                    dc = DC_STOP;
                    seq_phase = PH_4;
                end
                PH_4: begin
                    dc = DC_DUMP;
                    seq_mark = t;
                    seq_phase = PH_5;
                end
                PH_5: if (gap >= REST_S) begin
                    seq_phase = PH_1;
                    seq_test = seq_test + 7'd1;
                end
                default: ;
            endcase
        end else begin
            case (seq_phase)
                PH_1: begin
                    pr = seq_test[0] ? PR_NOSE : PR_SIDE;
                    seq_mark = t;
                    seq_phase = PH_2;
                end
                PH_2: if (gap >= ORIENT_S) begin
                    dc = DC_START;
                    seq_phase = PH_3;
                end
                PH_3: begin
                    tc = TC_RELEASE;
                    pr = PR_RELEASE;
                    seq_mark = t;
                    seq_phase = PH_4;
                end
                PH_4: if (gap >= LOG_S) begin
                    dc = DC_STOP;
                    seq_phase = PH_5;
                end
                PH_5: begin
                    seq_test = seq_test + 7'd1;
                    seq_phase = PH_1;
                    seq_mark = t;
                end
                default: ;
            endcase
        end
        return cmd_set(idx, tc, dc, pr, 1'b0);
    endfunction

    always @(posedge aclk) begin : scoreboard
        cmd_set_t got;
        cmd_set_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                n_reg = cfg_data;
            if (s_tvalid && s_tready) begin
                want = next_cmd_set(s_tuser[0], s_tdata);
                if (lit_flag)
                    want = lit_word;
                cmd_sets_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                sets_seen++;
                if (cmd_sets_due.size() == 0) begin
                    if (faults < 10)
                        $display("unexpected word %h at cycle %0d", m_tdata, cycles);
                    faults++;
                end else begin
                    want = cmd_sets_due.pop_front();
                    if (got.idx != want.idx || got.tc != want.tc || got.dc != want.dc ||
                        got.pr != want.pr || got.done != want.done || got.pad != 1'b0) begin
                        if (faults < 10) begin
                            $display("mismatch at cycle %0d (exp/got): index %0d/%0d %s",
                                     cycles, want.idx, got.idx, "");
                            $display("  thruster %0d/%0d data %0d/%0d prompt %0d/%0d",
                                     want.tc, got.tc, want.dc, got.dc, want.pr, got.pr);
                            $display("  complete %0d/%0d pad 0/%0d",
                                     want.done, got.done, got.pad);
                        end
                        faults++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : sink
        if ($urandom_range(0, 199) == 0)
            sink_jitter = !sink_jitter;
        if (calm || !aresetn) begin
            stall_left = 0;
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (sink_jitter && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send_word(input logic op, input logic [TIME_W-1:0] t, input logic lit,
                             input cmd_set_t want);
        if ($urandom_range(0, 39) == 0)
            src_jitter = !src_jitter;
        if (!calm && src_jitter && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= t;
        s_tuser <= op;
        lit_flag <= lit;
        lit_word <= want;
        do @(posedge aclk); while (!s_tready);
        words_fed++;
        if (words_fed >= WORDS_CALM)
            calm = 1;
    endtask

    // every word yields a result, so the block is idle once all have come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sets_seen < words_fed) @(posedge aclk);
    endtask

    task automatic program_count(input logic [NUM_W-1:0] n);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= n;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_campaign(input logic [NUM_W-1:0] n, input int ticks, input int stride,
                                input bit noisy);
        logic [TIME_W-1:0] now;
        int k;
        int roll;
        program_count(n);
        now = $urandom;
        send_word(IN_OP_RESTART, now, 1'b0, '0);
        for (k = 0; k < ticks; k++) begin
            roll = noisy ? $urandom_range(0, 99) : 100;
            if (roll < 1) begin
                send_word(IN_OP_RESTART, $urandom, 1'b0, '0);
            end else begin
                if (roll < 3)
                    now = $urandom;
                else if (roll < 5)
                    now = now - $urandom_range(1, 20);
                else
                    now = now + $urandom_range(0, stride);
                send_word(IN_OP_TICK, now, 1'b0, '0);
            end
        end
    endtask

    function automatic row_t word_row(input logic op, input logic [TIME_W-1:0] t,
                                      input logic lit, input cmd_set_t want);
        row_t r;
        r.kind = ROW_WORD;
        r.op = op;
        r.val = t;
        r.lit = lit;
        r.want = want;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [NUM_W-1:0] n);
        row_t r;
        r.kind = ROW_CFG;
        r.op = IN_OP_TICK;
        r.val = TIME_W'(n);
        r.lit = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic row_t tick_row(input logic [TIME_W-1:0] t);
        return word_row(IN_OP_TICK, t, 1'b0, '0);
    endfunction

    initial begin : stimulus
        row_t plan[$];
        cmd_set_t idle_set;
        logic [NUM_W-1:0] n;
        int roll;
        idle_set = cmd_set('0, TC_NONE, DC_NONE, PR_NONE, 1'b1);

        plan.push_back(word_row(IN_OP_TICK, 32'd0, 1'b1, idle_set));
        plan.push_back(cfg_row(6'd0));
        plan.push_back(word_row(IN_OP_RESTART, 32'hFFFF_FFFF, 1'b1, idle_set));
        plan.push_back(cfg_row(6'd63));
        plan.push_back(word_row(IN_OP_RESTART, 32'd0, 1'b1, idle_set));
        plan.push_back(cfg_row(6'd1));
        plan.push_back(word_row(IN_OP_RESTART, 32'd123, 1'b1,
                                cmd_set('0, TC_NONE, DC_NONE, PR_NONE, 1'b0)));
        // thruster tests 0 and 1, time wrapping through zero
        plan.push_back(tick_row(32'hFFFF_FFFE));
        plan.push_back(tick_row(32'hFFFF_FFFF));
        plan.push_back(tick_row(32'd0));
        plan.push_back(tick_row(32'd6));
        plan.push_back(tick_row(32'd6));
        plan.push_back(tick_row(32'd20));
        plan.push_back(tick_row(32'd20));
        plan.push_back(tick_row(32'd22));
        plan.push_back(tick_row(32'd28));
        plan.push_back(tick_row(32'd28));
        plan.push_back(tick_row(32'd42));
        // orientation tests
        plan.push_back(tick_row(32'd42));
        plan.push_back(tick_row(32'd57));
        plan.push_back(tick_row(32'd57));
        plan.push_back(tick_row(32'd63));
        plan.push_back(tick_row(32'd63));
        plan.push_back(tick_row(32'd63));
        plan.push_back(tick_row(32'd78));
        plan.push_back(tick_row(32'd78));
        plan.push_back(tick_row(32'd84));
        plan.push_back(tick_row(32'd84));
        plan.push_back(word_row(IN_OP_TICK, 32'd0, 1'b1,
                                cmd_set(7'd3, TC_NONE, DC_NONE, PR_NONE, 1'b1)));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                program_count(plan[i].val[NUM_W-1:0]);
            else
                send_word(plan[i].op, plan[i].val, plan[i].lit, plan[i].want);
        end

        run_campaign(6'd40, 620, 16, 1'b0);
        run_campaign(6'd63, 20, 6, 1'b1);
        while (words_fed < WORDS_TOTAL) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                n = ($urandom_range(0, 1) == 0) ? 6'd0 : NUM_W'($urandom_range(41, 63));
                run_campaign(n, 20, 6, 1'b1);
            end else begin
                n = (roll < 3) ? NUM_W'($urandom_range(4, 8)) : NUM_W'($urandom_range(1, 3));
                run_campaign(n, 12 * (2 * int'(n) + 2) + 8, 6, 1'b1);
            end
        end

        settle();
        repeat (4) @(posedge aclk);
        if (cmd_sets_due.size() != 0)
            faults++;
        if (faults == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
